/* hdl/tilt_pkg.sv */
// ----------------------------------------------------------------------------
// tilt_pkg
// Shared types, constants and helpers of the tilt angle tracker: fixed point
// angle limits, filter gains, register indexes, sequencer states and the
// arctangent table used by the CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

package tilt_pkg;

    // CORDIC iterations per atan2 (8 to 24)
    localparam int CORDIC_STEPS = 16;

    // CORDIC datapath widths
    localparam int CW = 51;
    localparam int ZW = 28;

    // angles in 1/128 degree
    localparam logic signed [17:0] ANG_FULL = 18'sd46080;
    localparam logic signed [17:0] ANG_HALF = 18'sd23040;

    // 180 degrees in 1/65536 degree
    localparam logic signed [ZW-1:0] Z_HALF_TURN = 28'sd11796480;

    // smoothing gains, Q0.16
    localparam logic signed [17:0] GAIN_STABLE   = 18'sd16384;
    localparam logic signed [17:0] GAIN_UNSTABLE = 18'sd2621;

    // register indexes
    localparam logic [3:0] CFG_WRIST_NEUTRAL  = 4'd0;
    localparam logic [3:0] CFG_PALM_NEUTRAL   = 4'd1;
    localparam logic [3:0] CFG_ACCEL_NEUTRAL  = 4'd2;
    localparam logic [3:0] CFG_COUPLING_WP    = 4'd3;
    localparam logic [3:0] CFG_COUPLING_PW    = 4'd4;
    localparam logic [3:0] CFG_ENTER_TOL      = 4'd5;
    localparam logic [3:0] CFG_EXIT_TOL       = 4'd6;
    localparam logic [3:0] CFG_DEADBAND       = 4'd7;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_MXX,
        S_MZZ,
        S_MYY,
        S_SQ1,
        S_SQ2,
        S_STAB,
        S_AXR,
        S_AZQ,
        S_CINIT,
        S_CITER,
        S_CFIN,
        S_DET,
        S_CHK,
        S_NUM,
        S_DVS,
        S_DIV,
        S_DFIN,
        S_WRAP,
        S_LOAD,
        S_SMW,
        S_SMW2,
        S_SMP,
        S_SMP2,
        S_OUT
    } t_state;

    // arctangent of 2^-i in 1/65536 degree
    function automatic logic [21:0] atan_val(input logic [4:0] idx);
        logic [21:0] v;
        begin
            unique case (idx)
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117304;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                5'd18:   v = 22'd14;
                5'd19:   v = 22'd7;
                5'd20:   v = 22'd4;
                5'd21:   v = 22'd2;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

    // wrap into [-180, 180] degrees for values within two turns
    function automatic logic signed [15:0] wrap_ang(input logic signed [17:0] v);
        logic signed [17:0] r;
        begin
            r = v;
            if (r >= ANG_FULL) begin
                r = r - ANG_FULL;
            end else if (r <= -ANG_FULL) begin
                r = r + ANG_FULL;
            end
            if (r > ANG_HALF) begin
                r = r - ANG_FULL;
            end else if (r < -ANG_HALF) begin
                r = r + ANG_FULL;
            end
            return r[15:0];
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/accel_tilt_angle_tracker_top.sv */
// ----------------------------------------------------------------------------
// accel_tilt_angle_tracker_top
// Tilt angle tracker: magnitude by integer square root, hysteresis stable
// flag, two CORDIC atan2, decoupling by division unless near singular, wrapped smoothing.
// ----------------------------------------------------------------------------
// Sequence: two 16-step square roots, two CORDIC runs of up to CORDIC_STEPS
//   iterations, and two 20-step restoring divisions with modular wrap when decoupling.
// Samples: not ready while busy; a new sample is taken only after the result transfers.
// Reset: synchronous active low; registers return to defaults, stable flag set,
//   filter unloaded, smoothed angles zero.
`default_nettype none

module accel_tilt_angle_tracker_top (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // sample channel
    input  wire                i_valid,
    output logic               o_ready,
    input  wire  signed [15:0] i_accel_x,
    input  wire  signed [15:0] i_accel_y,
    input  wire  signed [15:0] i_accel_z,
    // result channel
    output logic               o_valid,
    input  wire                i_ready,
    output logic signed [15:0] o_wrist_filtered,
    output logic signed [15:0] o_palm_filtered,
    output logic signed [15:0] o_wrist_decoupled,
    output logic signed [15:0] o_palm_decoupled,
    output logic        [15:0] o_accel_magnitude,
    output logic        [15:0] o_accel_error,
    output logic               o_is_stable,
    // register write channel
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire         [3:0]  i_cfg_index,
    input  wire         [15:0] i_cfg_data
);

    localparam int CWL = tilt_pkg::CW;
    localparam int ZWL = tilt_pkg::ZW;

    // turn limits at quotient width
    localparam logic signed [20:0] WV_HALF = 21'(tilt_pkg::ANG_HALF);
    localparam logic signed [20:0] WV_FULL = 21'(tilt_pkg::ANG_FULL);

    // control and state registers
    tilt_pkg::t_state r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_which, n_which;
    logic        r_stable, n_stable;
    logic        r_loaded, n_loaded;
    logic signed [15:0] r_sw, n_sw;
    logic signed [15:0] r_sp, n_sp;

    // configuration registers
    logic signed [15:0] r_wrist_neutral;
    logic signed [15:0] r_palm_neutral;
    logic        [15:0] r_accel_neutral;
    logic signed [15:0] r_cpl_wp;
    logic signed [15:0] r_cpl_pw;
    logic        [15:0] r_enter_tol;
    logic        [15:0] r_exit_tol;
    logic        [14:0] r_deadband;

    // payload registers
    logic signed [15:0] r_ax, n_ax, r_ay, n_ay, r_az, n_az;
    logic [31:0] r_sxz, n_sxz;
    logic [30:0] r_ayy, n_ayy;
    logic [31:0] r_sq, n_sq;
    logic [31:0] r_sv, n_sv;
    logic [32:0] r_res, n_res;
    logic [31:0] r_bit, n_bit;
    logic [15:0] r_q, n_q, r_r, n_r;
    logic [15:0] r_mag, n_mag, r_err, n_err;
    logic signed [32:0] r_py, n_py, r_px, n_px;
    logic signed [CWL-1:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [ZWL-1:0] r_cz, n_cz;
    logic signed [15:0] r_wm, n_wm, r_pm, n_pm;
    logic signed [31:0] r_det, n_det;
    logic signed [31:0] r_num, n_num;
    logic [30:0] r_ud, n_ud;
    logic [46:0] r_rem, n_rem;
    logic [19:0] r_quo, n_quo;
    logic        r_neg, n_neg;
    logic signed [20:0] r_wv, n_wv;
    logic signed [15:0] r_wd, n_wd, r_pd, n_pd;
    logic signed [35:0] r_sprod, n_sprod;

    // shared multiplier
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_p;

    // combinational helpers
    logic [32:0] sq_t;
    logic [32:0] sq_res_nx;
    logic [31:0] sq_sv_nx;
    logic        sq_take;
    logic [16:0] mag_diff;
    logic [15:0] err_v;
    logic signed [32:0] ci_y, ci_x, ci_xa, ci_ya;
    logic signed [CWL-1:0] cx_sh, cy_sh;
    logic signed [ZWL-1:0] atan_z, z_rnd;
    logic signed [17:0] ang_v;
    logic signed [15:0] neutral_sel;
    logic [31:0] adet32;
    logic [33:0] adet5;
    logic signed [15:0] own_ang;
    logic signed [35:0] num_full;
    logic [31:0] anum;
    logic [50:0] div_sh, div_rx;
    logic signed [20:0] q_ext;
    logic signed [15:0] wrap_res;
    logic signed [15:0] sm_tgt, sm_cur, sm_diff;
    logic signed [35:0] sm_rnd;
    logic signed [17:0] sm_sum;
    logic signed [17:0] gain;

    // zero small angles
    function automatic logic signed [15:0] apply_db(input logic signed [15:0] v,
                                                    input logic [14:0] db);
        logic [15:0] a;
        begin
            a = v[15] ? 16'(-v) : 16'(v);
            return (a < {1'b0, db}) ? 16'sd0 : v;
        end
    endfunction

    assign mul_p = mul_a * mul_b;
    assign gain  = r_stable ? tilt_pkg::GAIN_STABLE : tilt_pkg::GAIN_UNSTABLE;

    // sequencer and datapath next values
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_which  = r_which;
        n_stable = r_stable;
        n_loaded = r_loaded;
        n_sw     = r_sw;
        n_sp     = r_sp;
        n_ax     = r_ax;
        n_ay     = r_ay;
        n_az     = r_az;
        n_sxz    = r_sxz;
        n_ayy    = r_ayy;
        n_sq     = r_sq;
        n_sv     = r_sv;
        n_res    = r_res;
        n_bit    = r_bit;
        n_q      = r_q;
        n_r      = r_r;
        n_mag    = r_mag;
        n_err    = r_err;
        n_py     = r_py;
        n_px     = r_px;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_cz     = r_cz;
        n_wm     = r_wm;
        n_pm     = r_pm;
        n_det    = r_det;
        n_num    = r_num;
        n_ud     = r_ud;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_neg    = r_neg;
        n_wv     = r_wv;
        n_wd     = r_wd;
        n_pd     = r_pd;
        n_sprod  = r_sprod;
        mul_a    = 18'sd0;
        mul_b    = 18'sd0;
        o_ready  = 1'b0;
        o_valid  = 1'b0;

        // square root step
        sq_t      = r_res + {1'b0, r_bit};
        sq_take   = ({1'b0, r_sv} >= sq_t);
        sq_sv_nx  = sq_take ? (r_sv - sq_t[31:0]) : r_sv;
        sq_res_nx = sq_take ? ((r_res >> 1) + {1'b0, r_bit}) : (r_res >> 1);

        // magnitude error
        mag_diff = {1'b0, r_r} - {1'b0, r_accel_neutral};
        err_v    = mag_diff[16] ? 16'(-mag_diff) : mag_diff[15:0];

        // cordic setup and step
        ci_y   = r_which ? r_py : {{17{r_ay[15]}}, r_ay};
        ci_x   = r_which ? r_px : {17'b0, r_q};
        ci_xa  = ci_x[32] ? -ci_x : ci_x;
        ci_ya  = ci_x[32] ? -ci_y : ci_y;
        cx_sh  = r_cx >>> r_cnt;
        cy_sh  = r_cy >>> r_cnt;
        atan_z = {{(ZWL-22){1'b0}}, tilt_pkg::atan_val(r_cnt)};
        z_rnd  = (r_cz + 28'sd256) >>> 9;
        neutral_sel = r_which ? r_palm_neutral : r_wrist_neutral;
        ang_v  = {z_rnd[16], z_rnd[16:0]} - {{2{neutral_sel[15]}}, neutral_sel};

        // decoupling
        adet32   = r_det[31] ? 32'(-r_det) : 32'(r_det);
        adet5    = {3'b0, adet32[30:0]} + {1'b0, adet32[30:0], 2'b0};
        own_ang  = r_which ? r_pm : r_wm;
        num_full = ({{20{own_ang[15]}}, own_ang} <<< 14) - mul_p;
        anum     = r_num[31] ? 32'(-r_num) : 32'(r_num);
        div_sh   = {20'b0, r_ud} << r_cnt;
        div_rx   = {4'b0, r_rem};
        q_ext    = {1'b0, r_quo};
        if (r_wv > WV_HALF) begin
            wrap_res = 16'(r_wv - WV_FULL);
        end else if (r_wv < -WV_HALF) begin
            wrap_res = 16'(r_wv + WV_FULL);
        end else begin
            wrap_res = r_wv[15:0];
        end

        // smoothing
        sm_tgt  = (r_state == tilt_pkg::S_SMP || r_state == tilt_pkg::S_SMP2) ? r_pd : r_wd;
        sm_cur  = (r_state == tilt_pkg::S_SMP || r_state == tilt_pkg::S_SMP2) ? r_sp : r_sw;
        sm_diff = tilt_pkg::wrap_ang({{2{sm_tgt[15]}}, sm_tgt} - {{2{sm_cur[15]}}, sm_cur});
        sm_rnd  = (r_sprod + 36'sd32768) >>> 16;
        sm_sum  = {{2{sm_cur[15]}}, sm_cur} + sm_rnd[17:0];

        unique case (r_state)
            tilt_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_ax    = i_accel_x;
                    n_ay    = i_accel_y;
                    n_az    = i_accel_z;
                    n_state = tilt_pkg::S_MXX;
                end
            end
            tilt_pkg::S_MXX: begin
                mul_a   = {{2{r_ax[15]}}, r_ax};
                mul_b   = {{2{r_ax[15]}}, r_ax};
                n_sxz   = mul_p[31:0];
                n_state = tilt_pkg::S_MZZ;
            end
            tilt_pkg::S_MZZ: begin
                mul_a   = {{2{r_az[15]}}, r_az};
                mul_b   = {{2{r_az[15]}}, r_az};
                n_sxz   = r_sxz + mul_p[31:0];
                n_state = tilt_pkg::S_MYY;
            end
            tilt_pkg::S_MYY: begin
                mul_a   = {{2{r_ay[15]}}, r_ay};
                mul_b   = {{2{r_ay[15]}}, r_ay};
                n_ayy   = mul_p[30:0];
                n_sq    = r_sxz + {1'b0, mul_p[30:0]};
                n_sv    = r_sxz;
                n_res   = 33'd0;
                n_bit   = 32'h4000_0000;
                n_cnt   = 5'd0;
                n_state = tilt_pkg::S_SQ1;
            end
            tilt_pkg::S_SQ1: begin
                n_sv  = sq_sv_nx;
                n_res = sq_res_nx;
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    n_q     = sq_res_nx[15:0];
                    n_sv    = r_sq;
                    n_res   = 33'd0;
                    n_bit   = 32'h4000_0000;
                    n_cnt   = 5'd0;
                    n_state = tilt_pkg::S_SQ2;
                end
            end
            tilt_pkg::S_SQ2: begin
                n_sv  = sq_sv_nx;
                n_res = sq_res_nx;
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    n_r     = sq_res_nx[15:0];
                    n_state = tilt_pkg::S_STAB;
                end
            end
            tilt_pkg::S_STAB: begin
                n_mag = r_r;
                n_err = err_v;
                if (r_stable) begin
                    if (err_v > r_exit_tol) begin
                        n_stable = 1'b0;
                    end
                end else if (err_v < r_enter_tol) begin
                    n_stable = 1'b1;
                end
                n_state = tilt_pkg::S_AXR;
            end
            tilt_pkg::S_AXR: begin
                mul_a   = {{2{r_ax[15]}}, r_ax};
                mul_b   = {2'b0, r_r};
                n_py    = mul_p[32:0];
                n_state = tilt_pkg::S_AZQ;
            end
            tilt_pkg::S_AZQ: begin
                mul_a   = {{2{r_az[15]}}, r_az};
                mul_b   = {2'b0, r_q};
                n_px    = 33'({3'b0, r_ayy} + mul_p[33:0]);
                n_which = 1'b0;
                n_state = tilt_pkg::S_CINIT;
            end
            tilt_pkg::S_CINIT: begin
                n_cx = {{(CWL-49){ci_xa[32]}}, ci_xa, 16'b0};
                n_cy = {{(CWL-49){ci_ya[32]}}, ci_ya, 16'b0};
                if (ci_x[32]) begin
                    n_cz = ci_y[32] ? -tilt_pkg::Z_HALF_TURN : tilt_pkg::Z_HALF_TURN;
                end else begin
                    n_cz = '0;
                end
                n_cnt   = 5'd0;
                n_state = tilt_pkg::S_CITER;
            end
            tilt_pkg::S_CITER: begin
                if (r_cnt == 5'(tilt_pkg::CORDIC_STEPS) || r_cy == '0) begin
                    n_state = tilt_pkg::S_CFIN;
                end else begin
                    if (r_cy > 0) begin
                        n_cx = r_cx + cy_sh;
                        n_cy = r_cy - cx_sh;
                        n_cz = r_cz + atan_z;
                    end else begin
                        n_cx = r_cx - cy_sh;
                        n_cy = r_cy + cx_sh;
                        n_cz = r_cz - atan_z;
                    end
                    n_cnt = r_cnt + 5'd1;
                end
            end
            tilt_pkg::S_CFIN: begin
                if (r_which) begin
                    n_pm    = tilt_pkg::wrap_ang(ang_v);
                    n_state = tilt_pkg::S_DET;
                end else begin
                    n_wm    = tilt_pkg::wrap_ang(ang_v);
                    n_which = 1'b1;
                    n_state = tilt_pkg::S_CINIT;
                end
            end
            tilt_pkg::S_DET: begin
                mul_a   = {{2{r_cpl_wp[15]}}, r_cpl_wp};
                mul_b   = {{2{r_cpl_pw[15]}}, r_cpl_pw};
                n_det   = 32'(36'sd268435456 - mul_p);
                n_state = tilt_pkg::S_CHK;
            end
            tilt_pkg::S_CHK: begin
                n_ud = adet32[30:0];
                if (adet5 < 34'd268435456) begin
                    n_wd    = r_wm;
                    n_pd    = r_pm;
                    n_state = r_loaded ? tilt_pkg::S_SMW : tilt_pkg::S_LOAD;
                end else begin
                    n_which = 1'b0;
                    n_state = tilt_pkg::S_NUM;
                end
            end
            tilt_pkg::S_NUM: begin
                mul_a   = r_which ? {{2{r_cpl_pw[15]}}, r_cpl_pw}
                                  : {{2{r_cpl_wp[15]}}, r_cpl_wp};
                mul_b   = r_which ? {{2{r_wm[15]}}, r_wm} : {{2{r_pm[15]}}, r_pm};
                n_num   = num_full[31:0];
                n_state = tilt_pkg::S_DVS;
            end
            tilt_pkg::S_DVS: begin
                n_rem   = {2'b0, anum[30:0], 14'b0} + {16'b0, r_ud >> 1};
                n_neg   = r_num[31] ^ r_det[31];
                n_quo   = 20'd0;
                n_cnt   = 5'd19;
                n_state = tilt_pkg::S_DIV;
            end
            tilt_pkg::S_DIV: begin
                if (div_rx >= div_sh) begin
                    n_rem        = 47'(div_rx - div_sh);
                    n_quo[r_cnt] = 1'b1;
                end
                if (r_cnt == 5'd0) begin
                    n_state = tilt_pkg::S_DFIN;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            tilt_pkg::S_DFIN: begin
                n_wv    = r_neg ? -q_ext : q_ext;
                n_state = tilt_pkg::S_WRAP;
            end
            tilt_pkg::S_WRAP: begin
                if (r_wv >= WV_FULL) begin
                    n_wv = r_wv - WV_FULL;
                end else if (r_wv <= -WV_FULL) begin
                    n_wv = r_wv + WV_FULL;
                end else if (r_which) begin
                    n_pd    = wrap_res;
                    n_state = r_loaded ? tilt_pkg::S_SMW : tilt_pkg::S_LOAD;
                end else begin
                    n_wd    = wrap_res;
                    n_which = 1'b1;
                    n_state = tilt_pkg::S_NUM;
                end
            end
            tilt_pkg::S_LOAD: begin
                n_sw     = apply_db(r_wd, r_deadband);
                n_sp     = apply_db(r_pd, r_deadband);
                n_loaded = 1'b1;
                n_state  = tilt_pkg::S_OUT;
            end
            tilt_pkg::S_SMW: begin
                mul_a   = gain;
                mul_b   = {{2{sm_diff[15]}}, sm_diff};
                n_sprod = mul_p;
                n_state = tilt_pkg::S_SMW2;
            end
            tilt_pkg::S_SMW2: begin
                n_sw    = apply_db(tilt_pkg::wrap_ang(sm_sum), r_deadband);
                n_state = tilt_pkg::S_SMP;
            end
            tilt_pkg::S_SMP: begin
                mul_a   = gain;
                mul_b   = {{2{sm_diff[15]}}, sm_diff};
                n_sprod = mul_p;
                n_state = tilt_pkg::S_SMP2;
            end
            tilt_pkg::S_SMP2: begin
                n_sp    = apply_db(tilt_pkg::wrap_ang(sm_sum), r_deadband);
                n_state = tilt_pkg::S_OUT;
            end
            tilt_pkg::S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = tilt_pkg::S_IDLE;
                end
            end
        endcase
    end

    // control, filter state and register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= tilt_pkg::S_IDLE;
            r_cnt           <= 5'd0;
            r_which         <= 1'b0;
            r_stable        <= 1'b1;
            r_loaded        <= 1'b0;
            r_sw            <= 16'sd0;
            r_sp            <= 16'sd0;
            r_wrist_neutral <= 16'sd0;
            r_palm_neutral  <= 16'sd0;
            r_accel_neutral <= 16'd5018;
            r_cpl_wp        <= 16'sd0;
            r_cpl_pw        <= 16'sd0;
            r_enter_tol     <= 16'd307;
            r_exit_tol      <= 16'd461;
            r_deadband      <= 15'd64;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_which  <= n_which;
            r_stable <= n_stable;
            r_loaded <= n_loaded;
            r_sw     <= n_sw;
            r_sp     <= n_sp;
            // register write transfer
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tilt_pkg::CFG_WRIST_NEUTRAL: r_wrist_neutral <= i_cfg_data;
                    tilt_pkg::CFG_PALM_NEUTRAL:  r_palm_neutral  <= i_cfg_data;
                    tilt_pkg::CFG_ACCEL_NEUTRAL: r_accel_neutral <= i_cfg_data;
                    tilt_pkg::CFG_COUPLING_WP:   r_cpl_wp        <= i_cfg_data;
                    tilt_pkg::CFG_COUPLING_PW:   r_cpl_pw        <= i_cfg_data;
                    tilt_pkg::CFG_ENTER_TOL:     r_enter_tol     <= i_cfg_data;
                    tilt_pkg::CFG_EXIT_TOL:      r_exit_tol      <= i_cfg_data;
                    tilt_pkg::CFG_DEADBAND:      r_deadband      <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_ax    <= n_ax;
        r_ay    <= n_ay;
        r_az    <= n_az;
        r_sxz   <= n_sxz;
        r_ayy   <= n_ayy;
        r_sq    <= n_sq;
        r_sv    <= n_sv;
        r_res   <= n_res;
        r_bit   <= n_bit;
        r_q     <= n_q;
        r_r     <= n_r;
        r_mag   <= n_mag;
        r_err   <= n_err;
        r_py    <= n_py;
        r_px    <= n_px;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_cz    <= n_cz;
        r_wm    <= n_wm;
        r_pm    <= n_pm;
        r_det   <= n_det;
        r_num   <= n_num;
        r_ud    <= n_ud;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_neg   <= n_neg;
        r_wv    <= n_wv;
        r_wd    <= n_wd;
        r_pd    <= n_pd;
        r_sprod <= n_sprod;
    end

    // result ports
    assign o_cfg_ready       = 1'b1;
    assign o_wrist_filtered  = r_sw;
    assign o_palm_filtered   = r_sp;
    assign o_wrist_decoupled = r_wd;
    assign o_palm_decoupled  = r_pd;
    assign o_accel_magnitude = r_mag;
    assign o_accel_error     = r_err;
    assign o_is_stable       = r_stable;

endmodule

`default_nettype wire

/* tb/sv/tb_accel_tilt_angle_tracker_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_accel_tilt_angle_tracker_top
// Self-checking bench for the tilt angle tracker. A queue-fed driver sends
// acceleration samples, a monitor checks every result against an in-bench
// fixed point predictor, and register settings change between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_accel_tilt_angle_tracker_top;

    localparam int      RANDOM_ITEMS = 650;
    localparam longint  CYCLE_LIMIT  = 1500000;
    localparam longint  FULL_TURN    = 46080;
    localparam longint  HALF_TURN    = 23040;
    localparam longint  Q28_ONE      = 64'sd268435456;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } t_sample;

    typedef struct packed {
        logic [15:0] wf;
        logic [15:0] pf;
        logic [15:0] wd;
        logic [15:0] pd;
        logic [15:0] mag;
        logic [15:0] err;
        logic        st;
    } t_angles;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic o_ready;
    logic [15:0] ax_drv = '0, ay_drv = '0, az_drv = '0;
    logic o_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] o_wf, o_pf, o_wd, o_pd;
    logic [15:0] o_mag, o_err;
    logic o_st;
    logic cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [3:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    t_sample pending_samples[$];
    t_angles expected_angles[$];
    int      mismatches = 0;
    longint  cycles = 0;
    logic    quiet = 1'b0;
    logic    in_taken = 1'b0;

    // predictor copy of registers and state
    longint  p_wn, p_pn, p_b, p_c;
    longint  p_an, p_enter, p_exit, p_db;
    bit      p_stable, p_loaded;
    longint  p_ws, p_ps;

    longint  atan_lut[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0};

    accel_tilt_angle_tracker_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_ready(o_ready),
        .i_accel_x(ax_drv), .i_accel_y(ay_drv), .i_accel_z(az_drv),
        .o_valid(o_valid), .i_ready(out_ready),
        .o_wrist_filtered(o_wf), .o_palm_filtered(o_pf),
        .o_wrist_decoupled(o_wd), .o_palm_decoupled(o_pd),
        .o_accel_magnitude(o_mag), .o_accel_error(o_err), .o_is_stable(o_st),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- fixed point predictor ----------------
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint wrap_turn(input longint v);
        longint r;
        r = v % FULL_TURN;
        if (r > HALF_TURN) r = r - FULL_TURN;
        if (r < -HALF_TURN) r = r + FULL_TURN;
        return r;
    endfunction

    function automatic longint atan2_fix(input longint y, input longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
            x = -x;
            y = -y;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < tilt_pkg::CORDIC_STEPS && i < 24; i++) begin
            if (y == 0) break;
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + atan_lut[i];
            end else begin
                x = x - ys; y = y + xs; z = z - atan_lut[i];
            end
        end
        return (z + 256) >>> 9;
    endfunction

    function automatic longint round_div(input longint n, input longint d);
        longint unsigned un, ud;
        longint q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = longint'((un + ud / 2) / ud);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint ema_step(input longint cur, input longint tgt,
                                        input longint gain);
        longint diff;
        diff = wrap_turn(tgt - cur);
        return wrap_turn(cur + ((gain * diff + 32768) >>> 16));
    endfunction

    function automatic longint zero_small(input longint v);
        longint a;
        a = (v < 0) ? -v : v;
        return (a < p_db) ? 0 : v;
    endfunction

    task automatic predict_angles(input t_sample s);
        longint ax, ay, az, q, r, mag, err, wm, pm, wd, pd, det, adet, gain;
        t_angles e;
        ax = longint'($signed(s.x));
        ay = longint'($signed(s.y));
        az = longint'($signed(s.z));
        q = longint'(int_sqrt(ax * ax + az * az));
        r = longint'(int_sqrt(ax * ax + az * az + ay * ay));
        mag = (r > 65535) ? 65535 : r;
        err = mag - p_an;
        if (err < 0) err = -err;
        // hysteresis on the magnitude error
        if (p_stable) begin
            if (err > p_exit) p_stable = 1'b0;
        end else begin
            if (err < p_enter) p_stable = 1'b1;
        end
        gain = p_stable ? 16384 : 2621;
        wm = wrap_turn(atan2_fix(ay, q) - p_wn);
        pm = wrap_turn(atan2_fix(ax * r, ay * ay + az * q) - p_pn);
        // decoupling, bypassed when the matrix is near singular
        det = Q28_ONE - p_b * p_c;
        adet = (det < 0) ? -det : det;
        if (adet * 5 < Q28_ONE) begin
            wd = wm;
            pd = pm;
        end else begin
            wd = wrap_turn(round_div((wm * 16384 - p_b * pm) * 16384, det));
            pd = wrap_turn(round_div((pm * 16384 - p_c * wm) * 16384, det));
        end
        if (!p_loaded) begin
            p_ws = wd;
            p_ps = pd;
            p_loaded = 1'b1;
        end else begin
            p_ws = ema_step(p_ws, wd, gain);
            p_ps = ema_step(p_ps, pd, gain);
        end
        p_ws = zero_small(p_ws);
        p_ps = zero_small(p_ps);
        e.wf = p_ws[15:0];
        e.pf = p_ps[15:0];
        e.wd = wd[15:0];
        e.pd = pd[15:0];
        e.mag = mag[15:0];
        e.err = err[15:0];
        e.st = p_stable;
        expected_angles.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
        mismatches++;
    endtask

    // ---------------- sample driver ----------------
    always @(posedge i_clk) begin
        in_taken <= in_valid && o_ready;
        if (i_rst_n && in_valid && o_ready) begin
            predict_angles('{x: ax_drv, y: ay_drv, z: az_drv});
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_taken)) begin
            if (pending_samples.size() > 0 && (quiet || $urandom_range(99) >= 6)) begin
                t_sample s;
                s = pending_samples.pop_front();
                ax_drv <= s.x;
                ay_drv <= s.y;
                az_drv <= s.z;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------- result monitor ----------------
    always @(negedge i_clk) begin
        out_ready <= i_rst_n && (quiet || $urandom_range(99) >= 6);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && out_ready) begin
            if (expected_angles.size() == 0) begin
                report_mismatch("unexpected result", o_wf, 16'd0);
            end else begin
                t_angles e;
                e = expected_angles.pop_front();
                if (o_wf !== e.wf) report_mismatch("wrist_filtered", o_wf, e.wf);
                if (o_pf !== e.pf) report_mismatch("palm_filtered", o_pf, e.pf);
                if (o_wd !== e.wd) report_mismatch("wrist_decoupled", o_wd, e.wd);
                if (o_pd !== e.pd) report_mismatch("palm_decoupled", o_pd, e.pd);
                if (o_mag !== e.mag) report_mismatch("accel_magnitude", o_mag, e.mag);
                if (o_err !== e.err) report_mismatch("accel_error", o_err, e.err);
                if (o_st !== e.st) report_mismatch("is_stable", 16'(o_st), 16'(e.st));
            end
        end
    end

    // ---------------- run limit ----------------
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- register writes ----------------
    task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            tilt_pkg::CFG_WRIST_NEUTRAL: p_wn = longint'($signed(val));
            tilt_pkg::CFG_PALM_NEUTRAL:  p_pn = longint'($signed(val));
            tilt_pkg::CFG_ACCEL_NEUTRAL: p_an = longint'(val);
            tilt_pkg::CFG_COUPLING_WP:   p_b = longint'($signed(val));
            tilt_pkg::CFG_COUPLING_PW:   p_c = longint'($signed(val));
            tilt_pkg::CFG_ENTER_TOL:     p_enter = longint'(val);
            tilt_pkg::CFG_EXIT_TOL:      p_exit = longint'(val);
            tilt_pkg::CFG_DEADBAND:      p_db = longint'(val[14:0]);
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] wn, input logic [15:0] pn,
                             input logic [15:0] an, input logic [15:0] b,
                             input logic [15:0] c, input logic [15:0] en,
                             input logic [15:0] ex, input logic [15:0] db);
        write_reg(tilt_pkg::CFG_WRIST_NEUTRAL, wn);
        write_reg(tilt_pkg::CFG_PALM_NEUTRAL, pn);
        write_reg(tilt_pkg::CFG_ACCEL_NEUTRAL, an);
        write_reg(tilt_pkg::CFG_COUPLING_WP, b);
        write_reg(tilt_pkg::CFG_COUPLING_PW, c);
        write_reg(tilt_pkg::CFG_ENTER_TOL, en);
        write_reg(tilt_pkg::CFG_EXIT_TOL, ex);
        write_reg(tilt_pkg::CFG_DEADBAND, db);
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && !in_valid && expected_angles.size() == 0);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic add_sample(input int x, input int y, input int z);
        pending_samples.push_back('{x: x[15:0], y: y[15:0], z: z[15:0]});
    endtask

    // mostly near-gravity vectors so the stable flag toggles, some full range
    task automatic add_random(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 70) begin
                add_sample($urandom_range(11000) - 5500, $urandom_range(11000) - 5500,
                           $urandom_range(11000) - 5500);
            end else begin
                add_sample($urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        p_wn = 0; p_pn = 0; p_an = 5018; p_b = 0; p_c = 0;
        p_enter = 307; p_exit = 461; p_db = 64;
        p_stable = 1'b1; p_loaded = 1'b0; p_ws = 0; p_ps = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero sample, axis extremes, gravity directions
        add_sample(0, 0, 0);
        add_sample(32767, 0, 0);
        add_sample(-32768, 0, 0);
        add_sample(0, 32767, 0);
        add_sample(0, -32768, 0);
        add_sample(0, 0, 32767);
        add_sample(0, 0, -32768);
        add_sample(-32768, -32768, -32768);
        add_sample(32767, 32767, 32767);
        add_sample(0, 0, 5018);
        add_sample(0, 5018, 0);
        add_sample(5018, 0, 0);
        add_sample(-3000, 2000, -3500);
        add_sample(0, 0, -5018);
        add_sample(1, -1, 0);
        add_sample(0, 0, 5600);
        add_sample(0, 0, 5018);
        add_sample(0, 0, 4800);
        drain();

        // neutral extremes, strong coupling, tight hysteresis, no deadband
        write_all(16'sd23040, -16'sd23040, 16'd0, 16'h8000, 16'h8000, 16'd0, 16'd0, 16'd0);
        add_random(110);
        drain();

        // singular coupling, so angles pass through
        write_all(-16'sd23040, 16'sd23040, 16'd65535, 16'sd16384, 16'sd16384,
                  16'd65535, 16'd65535, 16'd23040);
        add_random(100);
        drain();

        // long stretch with no idling on either side
        quiet = 1'b1;
        write_all(16'sd1000, -16'sd500, 16'd5018, 16'sd32767, -16'sd32768,
                  16'd307, 16'd461, 16'hFFFF);
        write_reg(4'd8, 16'hFFFF);
        write_reg(4'd15, 16'h1234);
        add_random(120);
        drain();
        quiet = 1'b0;

        // random settings
        for (int k = 0; k < 3; k++) begin
            write_all(16'($urandom_range(46080) - 23040), 16'($urandom_range(46080) - 23040),
                      16'($urandom_range(4000, 6000)), 16'($urandom), 16'($urandom),
                      16'($urandom_range(600)), 16'($urandom_range(700)),
                      16'($urandom_range(2000)));
            add_random(80);
            drain();
        end

        // back to defaults
        write_all(16'd0, 16'd0, 16'd5018, 16'd0, 16'd0, 16'd307, 16'd461, 16'd64);
        add_random(80);
        drain();

        if (mismatches == 0 && expected_angles.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hdl/tilt_pkg.sv
hdl/accel_tilt_angle_tracker_top.sv
tb/sv/tb_accel_tilt_angle_tracker_top.sv
